// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; swas_ctrl is the one that includes them.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWAS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define SWAS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SWAS_ASSERT(lbl, clk, rstn, prop)
`define SWAS_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// File: hw/rtl/swas_pkg.sv
// Types and constants of the sliding window ARQ sender.
// No dependencies.
package swas_pkg;
    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int SEQ_W   = 31;
    localparam int LEN_W   = 11;
    localparam int TICK_W  = 32;
    localparam int TOT_W   = 48;
    localparam int WIN_W   = 7;
    localparam int TMO_W   = 16;
    localparam int CIDX_W  = 2;
    localparam logic [LEN_W-1:0] PAYLOAD_MAX = 11'd1024;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd8;

    typedef enum logic [1:0] {
        OP_OFFER = 2'd0, OP_ACK = 2'd1, OP_NACK = 2'd2, OP_TICK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_REFUSED = 3'd0, KIND_SEND = 3'd1, KIND_RESEND = 3'd2,
        KIND_ACKED = 3'd3, KIND_NONE = 3'd4
    } kind_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_WINDOW = 2'd0, CFG_TIMEOUT = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_NACK, ST_WALK, ST_EMIT
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic              fin;
        logic [TICK_W-1:0] tick;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  seq;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic              fin;
        logic [TOT_W-1:0]  bytes;
        logic              done;
        logic              last;
    } res_t;
endpackage

// File: hw/rtl/swas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: hw/rtl/swas_ctrl.sv
// Event sequencer: window state, live bits and slot walks over the slot RAM.
// Depends on swas_pkg and assert_macros.svh.
`include "assert_macros.svh"
module swas_ctrl
    import swas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  op_t                   in_op,
    input  logic [LEN_W-1:0]      in_len,
    input  logic                  in_fin,
    input  logic [SEQ_W-1:0]      in_peer,
    input  logic                  cfg_valid,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [TMO_W-1:0]      cfg_data,
    output logic                  push_valid,
    input  logic                  push_ready,
    output res_t                  push_res,
    output logic                  mem_we,
    output logic [SLOT_W-1:0]     mem_waddr,
    output slot_t                 mem_wdata,
    output logic                  mem_re,
    output logic [SLOT_W-1:0]     mem_raddr,
    input  slot_t                 mem_rdata
);
    state_t            state_reg, state_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [TMO_W-1:0]  tmo_reg, tmo_next;
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic [SEQ_W-1:0]  nts_reg, nts_next;
    logic [SEQ_W-1:0]  final_reg, final_next;
    logic              end_reg, end_next;
    logic [SLOTS-1:0]  live_reg, live_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [TOT_W-1:0]  acked_reg, acked_next;
    logic [SEQ_W-1:0]  peer_reg, peer_next;
    logic              mtick_reg, mtick_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    res_t              held_reg, held_next;
    logic              hval_reg, hval_next;

    logic              in_accept;
    logic [WIN_W-1:0]  lim;
    logic [SEQ_W:0]    win_end;
    logic [LEN_W-1:0]  len_sat;
    logic              fin_eff;
    logic [SLOT_W-1:0] offer_slot;
    logic              ack_match, due, stall, walk_end;
    logic [TICK_W-1:0] age;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    always_comb begin
        if (win_reg == '0) begin
            lim = WIN_W'(1);
        end else if (win_reg > WIN_W'(SLOTS)) begin
            lim = WIN_W'(SLOTS);
        end else begin
            lim = win_reg;
        end
    end

    assign win_end    = {1'b0, base_reg} + {{(SEQ_W+1-WIN_W){1'b0}}, lim};
    assign len_sat    = (in_len > PAYLOAD_MAX) ? PAYLOAD_MAX : in_len;
    assign fin_eff    = in_fin || (in_len == '0);
    assign offer_slot = nts_reg[SLOT_W-1:0];
    assign ack_match  = live_reg[idx_reg] && (mem_rdata.seq >= base_reg)
                        && (mem_rdata.seq <= peer_reg);
    assign age        = tick_reg - mem_rdata.tick;
    assign due        = live_reg[idx_reg] && (age >= {{(TICK_W-TMO_W){1'b0}}, tmo_reg});
    assign stall      = mtick_reg && due && hval_reg && !push_ready;
    assign walk_end   = (idx_reg == SLOT_W'(SLOTS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_op == OP_NACK) begin
                        state_next = ST_NACK;
                    end else if (in_op == OP_TICK ||
                                 (in_op == OP_ACK && in_peer >= base_reg)) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_NACK: state_next = ST_EMIT;
            ST_WALK: begin
                if (!stall && walk_end) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        win_next   = win_reg;
        tmo_next   = tmo_reg;
        base_next  = base_reg;
        nts_next   = nts_reg;
        final_next = final_reg;
        end_next   = end_reg;
        live_next  = live_reg;
        tick_next  = tick_reg;
        acked_next = acked_reg;
        peer_next  = peer_reg;
        mtick_next = mtick_reg;
        idx_next   = idx_reg;
        held_next  = held_reg;
        hval_next  = hval_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        push_valid = 1'b0;
        push_res   = held_reg;
        push_res.bytes = acked_reg;
        push_res.done  = end_reg && (base_reg > final_reg);
        push_res.last  = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW:  win_next = cfg_data[WIN_W-1:0];
                CFG_TIMEOUT: tmo_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                held_next = '0;
                held_next.kind = KIND_NONE;
                hval_next = 1'b0;
                idx_next  = '0;
                peer_next = in_peer;
                if (in_accept) begin
                    unique case (in_op)
                        OP_OFFER: begin
                            if (end_reg || ({1'b0, nts_reg} >= win_end)) begin
                                held_next.kind = KIND_REFUSED;
                            end else begin
                                mem_we         = 1'b0 | 1'b1;
                                mem_waddr      = offer_slot;
                                mem_wdata.seq  = nts_reg;
                                mem_wdata.len  = len_sat;
                                mem_wdata.fin  = fin_eff;
                                mem_wdata.tick = tick_reg;
                                live_next[offer_slot] = 1'b1;
                                if (fin_eff) begin
                                    final_next = nts_reg;
                                    end_next   = 1'b1;
                                end
                                nts_next       = nts_reg + SEQ_W'(1);
                                held_next.kind = KIND_SEND;
                                held_next.seq  = nts_reg;
                                held_next.slot = offer_slot;
                                held_next.len  = len_sat;
                                held_next.fin  = fin_eff;
                            end
                        end
                        OP_ACK: begin
                            mtick_next = 1'b0;
                            mem_re     = 1'b1;
                        end
                        OP_NACK: begin
                            mem_re    = 1'b1;
                            mem_raddr = in_peer[SLOT_W-1:0];
                        end
                        OP_TICK: begin
                            mtick_next = 1'b1;
                            tick_next  = tick_reg + TICK_W'(1);
                            mem_re     = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NACK: begin
                if (live_reg[peer_reg[SLOT_W-1:0]] && mem_rdata.seq == peer_reg) begin
                    mem_we          = 1'b1;
                    mem_waddr       = peer_reg[SLOT_W-1:0];
                    mem_wdata.tick  = tick_reg;
                    held_next.kind  = KIND_RESEND;
                    held_next.seq   = mem_rdata.seq;
                    held_next.slot  = peer_reg[SLOT_W-1:0];
                    held_next.len   = mem_rdata.len;
                    held_next.fin   = mem_rdata.fin;
                end
            end
            ST_WALK: begin
                if (!mtick_reg) begin
                    if (ack_match) begin
                        acked_next = acked_reg + {{(TOT_W-LEN_W){1'b0}}, mem_rdata.len};
                        live_next[idx_reg] = 1'b0;
                    end
                    if (walk_end) begin
                        base_next      = peer_reg + SEQ_W'(1);
                        held_next.kind = KIND_ACKED;
                    end
                end else if (!stall && due) begin
                    // a new resend found: the previous one goes out, not last
                    mem_we         = 1'b1;
                    mem_wdata.tick = tick_reg;
                    push_valid     = hval_reg;
                    held_next.kind = KIND_RESEND;
                    held_next.seq  = mem_rdata.seq;
                    held_next.slot = idx_reg;
                    held_next.len  = mem_rdata.len;
                    held_next.fin  = mem_rdata.fin;
                    hval_next      = 1'b1;
                end
                if (!stall && !walk_end) begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + SLOT_W'(1);
                    idx_next  = idx_reg + SLOT_W'(1);
                end
            end
            ST_EMIT: begin
                push_valid    = 1'b1;
                push_res.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            win_reg   <= WINDOW_RESET;
            tmo_reg   <= TIMEOUT_RESET;
            base_reg  <= SEQ_W'(1);
            nts_reg   <= SEQ_W'(1);
            final_reg <= '0;
            end_reg   <= 1'b0;
            live_reg  <= '0;
            tick_reg  <= '0;
            acked_reg <= '0;
            mtick_reg <= 1'b0;
            idx_reg   <= '0;
            hval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            win_reg   <= win_next;
            tmo_reg   <= tmo_next;
            base_reg  <= base_next;
            nts_reg   <= nts_next;
            final_reg <= final_next;
            end_reg   <= end_next;
            live_reg  <= live_next;
            tick_reg  <= tick_next;
            acked_reg <= acked_next;
            mtick_reg <= mtick_next;
            idx_reg   <= idx_next;
            hval_reg  <= hval_next;
        end
    end

    always_ff @(posedge aclk) begin
        peer_reg <= peer_next;
        held_reg <= held_next;
    end

    `SWAS_ASSERT(a_idle_no_push, aclk, aresetn, !(in_ready && push_valid))
    `SWAS_ASSERT_NEXT(a_stale_ack, aclk, aresetn,
        in_accept && in_op == OP_ACK && in_peer < base_reg, state_reg == ST_EMIT)
    `SWAS_ASSERT_NEXT(a_stall_holds, aclk, aresetn,
        state_reg == ST_WALK && stall, $stable(idx_reg))
endmodule

// File: hw/rtl/sliding_window_arq_sender.sv
// Top level of the sliding window ARQ sender: slot RAM, sequencer, output register.
// Depends on swas_pkg, swas_ram and swas_ctrl.
//
// One event per input transfer: offer (1 result), ack, nack or tick. Offers use states
// idle, emit; nacks idle, nack, emit; non-stale acks and ticks walk every slot of the
// slot RAM one per cycle through its single read port, a tick's walk pausing while
// the output stalls. A tick may give one resend per live slot; the last result of
// an event carries tlast. Stale acks, unmatched nacks and idle ticks give kind
// "nothing". There is no clearing pass: live bits live in flip-flops cleared by reset.
module sliding_window_arq_sender
    import swas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // chunk_length[10:0], peer_seq[41:11], zero
    input  logic [1:0]            s_tuser,   // operation[1:0]
    input  logic                  s_tlast,   // chunk_is_final
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [103:0]          m_tdata,   // send_seq[30:0], slot_index[36:31],
                                             // send_length[47:37], send_is_fin[48],
                                             // bytes_acked[96:49], transfer_done[97]
    output logic [2:0]            m_tuser,   // kind[2:0]
    output logic                  m_tlast,   // last_of_run
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [TMO_W-1:0]      cfg_data
);
    logic              push_valid, push_ready;
    res_t              push_res;
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    slot_t             mem_wdata, mem_rdata;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg;

    assign cfg_ready = 1'b1;

    swas_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    swas_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (op_t'(s_tuser)),
        .in_len     (s_tdata[10:0]),
        .in_fin     (s_tlast),
        .in_peer    (s_tdata[41:11]),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_res   (push_res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    assign push_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (push_valid && push_ready) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid && push_ready) begin
            out_reg <= push_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {6'b0, out_reg.done, out_reg.bytes, out_reg.fin, out_reg.len,
                       out_reg.slot, out_reg.seq};
endmodule

// File: sim/tb_top.sv
// Testbench for sliding_window_arq_sender: random and directed events, scoreboard check.
// Depends on swas_pkg and the sliding_window_arq_sender RTL.
`timescale 1ns / 100ps

import swas_pkg::*;

typedef struct {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic              fin;
    logic [TOT_W-1:0]  bytes;
    logic              done;
    logic              last;
} arq_res_t;

class arq_scoreboard;
    int unsigned win_lim;
    int unsigned tmo;
    logic [SEQ_W-1:0]  win_base, send_next, fin_seq;
    bit                eof;
    bit                live [SLOTS];
    logic [SEQ_W-1:0]  sseq [SLOTS];
    logic [LEN_W-1:0]  slen [SLOTS];
    bit                sfin [SLOTS];
    logic [TICK_W-1:0] stick [SLOTS];
    logic [TICK_W-1:0] now;
    logic [TOT_W-1:0]  total;
    arq_res_t          pending [$];
    int                errors;

    function new();
        win_lim = 8;
        tmo = 500;
        win_base = SEQ_W'(1);
        send_next = SEQ_W'(1);
        fin_seq = '0;
        eof = 0;
        now = '0;
        total = '0;
        errors = 0;
        foreach (live[i]) live[i] = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [TMO_W-1:0] v);
        if (idx == CFG_WINDOW) win_lim = 32'(v[WIN_W-1:0]);
        else if (idx == CFG_TIMEOUT) tmo = 32'(v);
    endfunction

    function void push(kind_t k, int s);
        arq_res_t r;
        r.kind = k;
        r.seq = (s >= 0) ? sseq[s] : '0;
        r.slot = (s >= 0) ? s[SLOT_W-1:0] : '0;
        r.len = (s >= 0) ? slen[s] : '0;
        r.fin = (s >= 0) ? sfin[s] : 1'b0;
        r.bytes = total;
        r.done = eof && (win_base > fin_seq);
        r.last = 0;
        pending.push_back(r);
    endfunction

    // accepted input event: update state and queue the results it causes
    function void note_event(op_t op, logic [LEN_W-1:0] len_in, bit fin_in,
                             logic [SEQ_W-1:0] peer);
        int unsigned lim;
        int n;
        int s;
        logic [LEN_W-1:0] l;
        bit f;
        logic [32:0] lim_end;
        n = pending.size();
        l = len_in;
        f = fin_in;
        case (op)
            OP_OFFER: begin
                lim = (win_lim < 1) ? 1 : (win_lim > SLOTS) ? SLOTS : win_lim;
                lim_end = {2'b0, win_base} + lim;
                if (eof || {2'b0, send_next} >= lim_end) push(KIND_REFUSED, -1);
                else begin
                    s = int'(send_next % SLOTS);
                    if (l > PAYLOAD_MAX) l = PAYLOAD_MAX;
                    if (l == 0) f = 1;
                    live[s] = 1;
                    sseq[s] = send_next;
                    slen[s] = l;
                    sfin[s] = f;
                    stick[s] = now;
                    if (f) begin
                        fin_seq = send_next;
                        eof = 1;
                    end
                    send_next = send_next + 1'b1;
                    push(KIND_SEND, s);
                end
            end
            OP_ACK: begin
                if (peer < win_base) push(KIND_NONE, -1);
                else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (live[i] && sseq[i] >= win_base && sseq[i] <= peer) begin
                            total = total + slen[i];
                            live[i] = 0;
                        end
                    win_base = peer + 1'b1;
                    push(KIND_ACKED, -1);
                end
            end
            OP_NACK: begin
                s = int'(peer % SLOTS);
                if (live[s] && sseq[s] == peer) begin
                    stick[s] = now;
                    push(KIND_RESEND, s);
                end else push(KIND_NONE, -1);
            end
            default: begin
                now = now + 1;
                for (int i = 0; i < SLOTS; i++)
                    if (live[i] && (now - stick[i]) >= tmo) begin
                        stick[i] = now;
                        push(KIND_RESEND, i);
                    end
                if (pending.size() == n) push(KIND_NONE, -1);
            end
        endcase
        pending[pending.size()-1].last = 1;
    endfunction

    task report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    task check_result(logic [2:0] kind, logic [103:0] d, logic last);
        arq_res_t e;
        if (pending.size() == 0) begin
            report("unexpected result kind", kind, 0);
            return;
        end
        e = pending.pop_front();
        if (kind != e.kind) report("kind", kind, e.kind);
        if (d[30:0] != e.seq) report("send_seq", d[30:0], e.seq);
        if (d[36:31] != e.slot) report("slot_index", d[36:31], e.slot);
        if (d[47:37] != e.len) report("send_length", d[47:37], e.len);
        if (d[48] != e.fin) report("send_is_fin", d[48], e.fin);
        if (d[96:49] != e.bytes) report("bytes_acked", d[96:49], e.bytes);
        if (d[97] != e.done) report("transfer_done", d[97], e.done);
        if (last != e.last) report("last_of_run", last, e.last);
    endtask
endclass

module tb_top;
    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0, s_tready, s_tlast = 0;
    logic [47:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid, m_tready = 0, m_tlast;
    logic [103:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_valid = 0, cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [TMO_W-1:0] cfg_data = '0;

    arq_scoreboard sb;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_off = 0;

    sliding_window_arq_sender uut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // sink: random stalls and a counted hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_event(op_t op, logic [LEN_W-1:0] len, bit fin,
                              logic [SEQ_W-1:0] peer);
        // the block is never ready in the cycle right after a transfer
        @(posedge aclk);
        while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tlast <= fin;
        s_tdata <= {6'b0, peer, len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_event(op, len, fin, peer);
        s_tvalid <= 0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [TMO_W-1:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, v);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // mostly sequences near the window: offers, ticks, and acks and nacks near the window base
    task automatic random_event();
        int r;
        logic [SEQ_W-1:0] p;
        logic [LEN_W-1:0] l;
        r = $urandom_range(99);
        p = SEQ_W'(sb.win_base + $urandom_range(SLOTS) - 2);
        if ($urandom_range(19) == 0) p = SEQ_W'($urandom);
        l = ($urandom_range(9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(PAYLOAD_MAX));
        if (r < 45)
            send_event(OP_OFFER, l, ($urandom_range(29) == 0), SEQ_W'($urandom));
        else if (r < 60)
            send_event(OP_ACK, LEN_W'($urandom), 1'($urandom_range(1)), p);
        else if (r < 75)
            send_event(OP_NACK, LEN_W'($urandom), 1'($urandom_range(1)), p);
        else
            send_event(OP_TICK, LEN_W'($urandom), 1'($urandom_range(1)),
                       SEQ_W'($urandom));
    endtask

    initial begin
        #20000000;
        $display("[sliding_window_arq_sender] ERROR");
        $finish;
    end

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes and special cases, first with reset settings, then with a timeout of 1
        send_event(OP_TICK, '0, 1'b0, '0);
        send_event(OP_NACK, '0, 1'b0, SEQ_W'(5));
        send_event(OP_ACK, '0, 1'b0, '0);
        send_event(OP_OFFER, 11'h7FF, 1'b0, '0);
        send_event(OP_OFFER, PAYLOAD_MAX, 1'b0, '1);
        send_event(OP_OFFER, LEN_W'(1), 1'b0, '0);
        for (int i = 0; i < 6; i++) send_event(OP_OFFER, LEN_W'(100 + i), 1'b0, '0);
        send_event(OP_NACK, '0, 1'b1, SEQ_W'(2));
        send_event(OP_ACK, '0, 1'b0, SEQ_W'(3));
        send_event(OP_ACK, '0, 1'b0, SEQ_W'(2));
        send_event(OP_OFFER, '0, 1'b0, '0);
        send_event(OP_OFFER, LEN_W'(5), 1'b1, '0);
        drain();
        write_reg(CFG_TIMEOUT, TMO_W'(1));
        send_event(OP_TICK, '0, 1'b0, '0);
        send_event(OP_TICK, '0, 1'b0, '0);
        send_event(OP_ACK, '0, 1'b0, '1);
        send_event(OP_NACK, '0, 1'b0, '1);
        drain();

        // eof reached: further runs exercise refusals, acks, ticks, nacks
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0; sink_stall_pct = 0; end
                1: begin src_idle_pct = 66; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 66; end
                default: begin src_idle_pct = 14; sink_stall_pct = 14; end
            endcase
            drain();
            write_reg(CFG_WINDOW, TMO_W'((ph == 0) ? 0 : (ph == 1) ? 127 : (ph == 2) ? 64 :
                      (ph == 3) ? 1 : $urandom_range(2, 64)));
            write_reg(CFG_TIMEOUT, (ph == 4) ? 16'hFFFF : TMO_W'($urandom_range(1, 12)));
            if (ph == 2) hold_off = 400;
            for (int k = 0; k < 40; k++) random_event();
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[sliding_window_arq_sender] OK");
        else
            $display("[sliding_window_arq_sender] ERROR");
        $finish;
    end
endmodule
